// ----- hdl/crcfr_pkg.sv -----
// Shared types, constants and the CRC byte step for the frame receiver.
package crcfr_pkg;

    localparam int FRAME_LEN   = 11;
    localparam int PAYLOAD_LEN = 7;
    localparam int FILL_W      = 4;
    localparam int CNT_W       = 3;

    localparam logic [3:0]  NUM_COMMANDS = 4'd9;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [7:0]  HEADER_RESET = 8'hAA;
    localparam logic [7:0]  TAIL_RESET   = 8'h55;
    localparam logic [7:0]  DONE_VALUE   = 8'h01;

    // request codes
    localparam logic [1:0] REQ_BYTE    = 2'd0;
    localparam logic [1:0] REQ_ARM     = 2'd1;
    localparam logic [1:0] REQ_CONSUME = 2'd2;

    // register indexes
    localparam logic CFG_HEADER = 1'b0;
    localparam logic CFG_TAIL   = 1'b1;

    // result kinds
    localparam logic KIND_FRAME   = 1'b0;
    localparam logic KIND_CONSUME = 1'b1;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
        logic [3:0] cmd_mode;
    } req_t;

    typedef struct packed {
        logic        result_kind;
        logic        crc_ok;
        logic [7:0]  frame_region;
        logic [7:0]  frame_mode;
        logic [7:0]  frame_done;
        logic [15:0] frame_data;
        logic        active_cleared;
        logic        flag_taken;
    } rsp_t;

    typedef struct packed {
        logic load_byte;
        logic arm;
        logic latch_cmd;
        logic drop;
        logic crc_init;
        logic crc_step;
        logic emit_frame;
        logic emit_consume;
    } dp_cmd_t;

    typedef struct packed {
        logic fill_zero;
        logic fill_full;
        logic front_is_header;
        logic tail_match;
        logic crc_last;
    } dp_status_t;

    // One byte of reflected Modbus CRC-16: eight shift steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ----- hdl/crc_frame_receiver_with_ack.sv -----
// Top level of the framed byte receiver with CRC-16 check and completion flags.
//
// Request channel (req_valid / req_stall / req): one word per received byte,
// arm command or consume request. Response channel (rsp_valid / rsp_stall /
// rsp): one word per taken frame and per consume request. Config port
// (cfg_we / cfg_index / cfg_data) sets the header and tail byte values.
//
// Steps after a word is accepted:
//   arm word          applied as it is taken, no response
//   byte, no frame    search step: drop front bytes (one shift of the window per
//                     cycle) until a header leads and a full window has its tail
//   frame-ending byte search step, CRC pass over the seven payload bytes (one
//                     payload byte per cycle), then a load step to rsp_valid;
//                     the block is then idle and takes the next word
//   consume word      a load step to rsp_valid, then idle for the next word
// The block works on one word at a time; req_stall is high while it is busy.
// A loaded response waits in the output register while the next word is
// taken; a second response waits in its load step until rsp_stall drops.
// Reset empties the window, clears all completion flags and the active
// command, and restores the header and tail values to their defaults.
module crc_frame_receiver_with_ack (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  crcfr_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output crcfr_pkg::rsp_t rsp,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [7:0]      cfg_data
);

    crcfr_pkg::dp_cmd_t    cmd;
    crcfr_pkg::dp_status_t status;

    crcfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .status    (status)
    );

    crcfr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .rsp       (rsp)
    );

endmodule

// ----- hdl/crcfr_ctrl.sv -----
// Controller state machine: sequences header search, CRC pass and result loading.
module crcfr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic [1:0]            req_type,
    output logic                  req_stall,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output crcfr_pkg::dp_cmd_t    cmd,
    input  crcfr_pkg::dp_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STRIP,
        ST_CRC,
        ST_EMIT_FRAME,
        ST_EMIT_CONSUME
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   accept;
    logic   slot_free;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        crcfr_pkg::REQ_BYTE:
                        begin
                            cmd.load_byte = 1'b1;
                            state_next    = ST_STRIP;
                        end
                        crcfr_pkg::REQ_ARM:
                            cmd.arm = 1'b1;
                        crcfr_pkg::REQ_CONSUME:
                        begin
                            cmd.latch_cmd = 1'b1;
                            state_next    = ST_EMIT_CONSUME;
                        end
                        default: ;
                    endcase
                end
            end
            ST_STRIP:
            begin
                // drop one byte a cycle until the front is a header; a full window with a wrong tail drops too
                priority if (!status.fill_zero && !status.front_is_header)
                    cmd.drop = 1'b1;
                else if (status.fill_full && !status.tail_match)
                    cmd.drop = 1'b1;
                else if (status.fill_full)
                begin
                    cmd.crc_init = 1'b1;
                    state_next   = ST_CRC;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_CRC:
            begin
                cmd.crc_step = 1'b1;
                if (status.crc_last)
                    state_next = ST_EMIT_FRAME;
            end
            ST_EMIT_FRAME:
            begin
                if (slot_free)
                begin
                    cmd.emit_frame = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_EMIT_CONSUME:
            begin
                if (slot_free)
                begin
                    cmd.emit_consume = 1'b1;
                    rsp_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ----- hdl/crcfr_datapath.sv -----
// Datapath: byte window, CRC register, completion flags, active mode and result register.
module crcfr_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  crcfr_pkg::req_t       req,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [7:0]            cfg_data,
    input  crcfr_pkg::dp_cmd_t    cmd,
    output crcfr_pkg::dp_status_t status,
    output crcfr_pkg::rsp_t       rsp
);

    logic [7:0]                     win_reg [crcfr_pkg::FRAME_LEN];
    logic [7:0]                     win_next [crcfr_pkg::FRAME_LEN];
    logic [crcfr_pkg::FILL_W-1:0]   fill_reg, fill_next;
    logic [15:0]                    flags_reg, flags_next;
    logic [3:0]                     active_reg, active_next;
    logic [7:0]                     header_reg, tail_reg;
    logic [15:0]                    crc_reg;
    logic [crcfr_pkg::CNT_W-1:0]    cnt_reg;
    logic [3:0]                     mode_reg;
    crcfr_pkg::rsp_t                rsp_reg, rsp_next;

    logic [crcfr_pkg::FILL_W-1:0]   pay_idx;
    logic [7:0]                     pay_byte;
    logic                           frame_ok;
    logic                           frame_done;
    logic [7:0]                     frame_mode;
    logic                           frame_mode_valid;
    logic                           frame_clears;
    logic                           arm_valid;

    assign pay_idx  = crcfr_pkg::FILL_W'(cnt_reg) + crcfr_pkg::FILL_W'(1);
    assign pay_byte = win_reg[pay_idx];

    assign frame_ok   = (win_reg[8] == crc_reg[7:0]) && (win_reg[9] == crc_reg[15:8]);
    assign frame_mode = win_reg[2];
    assign frame_done = frame_ok && (win_reg[3] == crcfr_pkg::DONE_VALUE);
    assign frame_mode_valid = (frame_mode != 8'd0)
                           && (frame_mode <= {4'd0, crcfr_pkg::NUM_COMMANDS});
    assign frame_clears = frame_done && (active_reg != 4'd0)
                       && ({4'd0, active_reg} == frame_mode);
    assign arm_valid = (req.cmd_mode != 4'd0) && (req.cmd_mode <= crcfr_pkg::NUM_COMMANDS);

    assign status.fill_zero       = (fill_reg == '0);
    assign status.fill_full       = (fill_reg == crcfr_pkg::FILL_W'(crcfr_pkg::FRAME_LEN));
    assign status.front_is_header = (win_reg[0] == header_reg);
    assign status.tail_match      = (win_reg[crcfr_pkg::FRAME_LEN-1] == tail_reg);
    assign status.crc_last        = (cnt_reg == crcfr_pkg::CNT_W'(crcfr_pkg::PAYLOAD_LEN - 1));

    assign rsp = rsp_reg;

    // window and fill count
    always_comb
    begin
        win_next  = win_reg;
        fill_next = fill_reg;
        if (cmd.load_byte)
        begin
            for (int i = 0; i < crcfr_pkg::FRAME_LEN; i++)
            begin
                if (fill_reg == crcfr_pkg::FILL_W'(i))
                    win_next[i] = req.rx_byte;
            end
            fill_next = fill_reg + crcfr_pkg::FILL_W'(1);
        end
        else if (cmd.drop)
        begin
            for (int i = 0; i < crcfr_pkg::FRAME_LEN - 1; i++)
                win_next[i] = win_reg[i+1];
            fill_next = fill_reg - crcfr_pkg::FILL_W'(1);
        end
        else if (cmd.emit_frame)
            fill_next = '0;
    end

    // flags, active mode and result word
    always_comb
    begin
        flags_next  = flags_reg;
        active_next = active_reg;
        rsp_next    = rsp_reg;
        if (cmd.arm && arm_valid)
        begin
            active_next              = req.cmd_mode;
            flags_next[req.cmd_mode] = 1'b0;
        end
        if (cmd.emit_consume)
        begin
            rsp_next             = '0;
            rsp_next.result_kind = crcfr_pkg::KIND_CONSUME;
            rsp_next.flag_taken  = flags_reg[mode_reg];
            flags_next[mode_reg] = 1'b0;
        end
        if (cmd.emit_frame)
        begin
            if (frame_done && frame_mode_valid)
                flags_next[frame_mode[3:0]] = 1'b1;
            if (frame_clears)
                active_next = 4'd0;
            rsp_next.result_kind    = crcfr_pkg::KIND_FRAME;
            rsp_next.crc_ok         = frame_ok;
            rsp_next.frame_region   = win_reg[1];
            rsp_next.frame_mode     = frame_mode;
            rsp_next.frame_done     = win_reg[3];
            rsp_next.frame_data     = {win_reg[5], win_reg[4]};
            rsp_next.active_cleared = frame_clears;
            rsp_next.flag_taken     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            flags_reg  <= '0;
            active_reg <= 4'd0;
            header_reg <= crcfr_pkg::HEADER_RESET;
            tail_reg   <= crcfr_pkg::TAIL_RESET;
        end
        else
        begin
            fill_reg   <= fill_next;
            flags_reg  <= flags_next;
            active_reg <= active_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    crcfr_pkg::CFG_HEADER: header_reg <= cfg_data;
                    crcfr_pkg::CFG_TAIL:   tail_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        rsp_reg <= rsp_next;
        if (cmd.latch_cmd)
            mode_reg <= req.cmd_mode;
        if (cmd.crc_init)
        begin
            crc_reg <= crcfr_pkg::CRC_INIT;
            cnt_reg <= '0;
        end
        else if (cmd.crc_step)
        begin
            crc_reg <= crcfr_pkg::crc_byte(crc_reg, pay_byte);
            cnt_reg <= cnt_reg + crcfr_pkg::CNT_W'(1);
        end
    end

endmodule

// ----- hdl/crcfr_checker.sv -----
// Port-level checks for the frame receiver, bound to the top level.
module crcfr_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_stall,
    input crcfr_pkg::req_t req,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input crcfr_pkg::rsp_t rsp
);

    // hold a stalled response word
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response word changed");

    // consume answers carry only the flag
    a_consume_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.result_kind == crcfr_pkg::KIND_CONSUME) |->
            !rsp.crc_ok && !rsp.active_cleared && (rsp.frame_region == 8'd0)
            && (rsp.frame_mode == 8'd0) && (rsp.frame_done == 8'd0)
            && (rsp.frame_data == 16'd0))
        else $error("consume answer carries frame fields");

    // a frame clears the active command only with a good CRC and done set
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.result_kind == crcfr_pkg::KIND_FRAME) |->
            !rsp.flag_taken
            && (!rsp.active_cleared
                || (rsp.crc_ok && (rsp.frame_done == crcfr_pkg::DONE_VALUE))))
        else $error("frame result with inconsistent flags");

    // a received byte always goes through a search step
    a_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req.req_type == crcfr_pkg::REQ_BYTE) |=> req_stall)
        else $error("byte accepted without search step");

endmodule

bind crc_frame_receiver_with_ack crcfr_checker u_crcfr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
